// File: hdl/ifm_pkg.sv
// ----------------------------------------------------------------------------
// Interconnector flow margins package
// Shared widths, register indexes and the pipeline sideband type.
// ----------------------------------------------------------------------------
package ifm_pkg;

    localparam int MARGIN_W       = 32;
    localparam int DEMAND_W       = 31;
    localparam int CAP_W          = 31;
    localparam int SUM_W          = DEMAND_W + 1;
    localparam int ALPHA_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic REG_POLICY_MODE   = 1'b0;
    localparam logic REG_LINK_CAPACITY = 1'b1;

    // Sideband that travels beside the alpha divider.
    typedef struct packed {
        logic signed [MARGIN_W-1:0] margin_a;
        logic signed [MARGIN_W-1:0] margin_b;
        logic signed [MARGIN_W-1:0] veto_flow;
        logic                       use_share;
        logic                       sum_zero;
    } ifm_tag_t;

endpackage

// File: hdl/interconnector_flow_margins.sv
// ----------------------------------------------------------------------------
// Interconnector flow margins
// Computes the flow over a capacity-limited link between two areas and the
// resulting margins, under a veto or a demand-proportional share policy.
// ----------------------------------------------------------------------------
// Stages: input, the alpha divider stages, multiply, subtract, clamp and output.
// Throughput: one transaction per cycle; every stage moves on when the stage
// after it is empty or moving, so bubbles close up under back-pressure.
// The depth is set by the alpha divider, one quotient bit per stage.
// Reset clears the pipeline valid bits and both configuration registers.
// ----------------------------------------------------------------------------
module interconnector_flow_margins #(
    parameter int ALPHA_BITS = ifm_pkg::ALPHA_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ifm_pkg::CAP_W-1:0]  cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // margin_a [31:0], margin_b [63:32], demand_a [94:64], demand_b [125:95]
    input  logic [127:0]               s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // new_margin_a [31:0], new_margin_b [63:32], link_flow [95:64]
    output logic [95:0]                m_tdata
);

    localparam int MW     = ifm_pkg::MARGIN_W;
    localparam int CW     = ifm_pkg::CAP_W;
    localparam int ALPHA_W = ALPHA_BITS + 1;
    localparam int PROD_W = ALPHA_W + 1 + MW;
    localparam int DIFF_W = PROD_W + 1;
    localparam int SH_W   = DIFF_W - ALPHA_BITS;
    localparam int NST    = ALPHA_BITS + 6;
    localparam int ST_MUL = ALPHA_BITS + 2;
    localparam int ST_SUB = ALPHA_BITS + 3;
    localparam int ST_CLP = ALPHA_BITS + 4;
    localparam int ST_OUT = ALPHA_BITS + 5;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1) << ALPHA_BITS;
    localparam logic [ALPHA_W-1:0] ALPHA_HALF = ALPHA_W'(1) << (ALPHA_BITS - 1);

    // Configuration.
    logic          policy_mode_reg;
    logic [CW-1:0] link_capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg   <= 1'b0;
            link_capacity_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ifm_pkg::REG_POLICY_MODE:   policy_mode_reg   <= cfg_data[0];
                ifm_pkg::REG_LINK_CAPACITY: link_capacity_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Pipeline control.
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        for (int k = 0; k < NST; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NST-1];

    // Stage 0: unpack, demand sum, veto flow and the share condition.
    logic signed [MW-1:0]           in_ma;
    logic signed [MW-1:0]           in_mb;
    logic [ifm_pkg::DEMAND_W-1:0]   in_da;
    logic [ifm_pkg::DEMAND_W-1:0]   in_db;
    logic signed [MW:0]             ma_x;
    logic signed [MW:0]             mb_x;
    logic signed [MW:0]             cap_x;
    logic signed [MW:0]             total;
    logic [MW:0]                    abs_a;
    logic [MW:0]                    abs_b;
    logic [MW:0]                    min_ab;
    logic [MW:0]                    min_all;
    ifm_pkg::ifm_tag_t              tag0_next;
    logic [ifm_pkg::SUM_W-1:0]      sum0_next;

    assign in_ma = s_tdata[31:0];
    assign in_mb = s_tdata[63:32];
    assign in_da = s_tdata[94:64];
    assign in_db = s_tdata[125:95];

    always_comb
    begin
        ma_x    = {in_ma[MW-1], in_ma};
        mb_x    = {in_mb[MW-1], in_mb};
        cap_x   = {2'b00, link_capacity_reg};
        total   = ma_x + mb_x;
        abs_a   = in_ma[MW-1] ? ((MW+1)'(0) - ma_x) : ma_x;
        abs_b   = in_mb[MW-1] ? ((MW+1)'(0) - mb_x) : mb_x;
        min_ab  = (abs_a < abs_b) ? abs_a : abs_b;
        min_all = (min_ab < cap_x) ? min_ab : cap_x;

        tag0_next.margin_a = in_ma;
        tag0_next.margin_b = in_mb;
        // The minimum never exceeds the capacity, so it fits in MW bits.
        if (in_ma[MW-1] && !in_mb[MW-1] && (in_mb != '0))
        begin
            tag0_next.veto_flow = min_all[MW-1:0];
        end
        else if (!in_ma[MW-1] && (in_ma != '0) && in_mb[MW-1])
        begin
            tag0_next.veto_flow = MW'(0) - min_all[MW-1:0];
        end
        else
        begin
            tag0_next.veto_flow = '0;
        end
        tag0_next.use_share = policy_mode_reg && total[MW] && (ma_x < cap_x) && (mb_x < cap_x);
        sum0_next           = {1'b0, in_da} + {1'b0, in_db};
        tag0_next.sum_zero  = (sum0_next == '0);
    end

    ifm_pkg::ifm_tag_t            tag0_reg;
    logic [ifm_pkg::DEMAND_W-1:0] da0_reg;
    logic [ifm_pkg::SUM_W-1:0]    sum0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tag0_reg <= tag0_next;
            da0_reg  <= in_da;
            sum0_reg <= sum0_next;
        end
    end

    // Alpha divider stages.
    logic [ALPHA_W-1:0] div_alpha;
    ifm_pkg::ifm_tag_t  div_tag;

    ifm_alpha_div #(
        .ALPHA_BITS (ALPHA_BITS)
    ) u_div (
        .clk      (clk),
        .en       (en[ALPHA_BITS+1:1]),
        .dividend (da0_reg),
        .divisor  (sum0_reg),
        .tag_in   (tag0_reg),
        .alpha    (div_alpha),
        .tag_out  (div_tag)
    );

    // Multiply stage.
    logic [ALPHA_W-1:0]        alpha;
    logic [ALPHA_W-1:0]        alpha_rest;
    logic signed [PROD_W-1:0]  prod_a_next;
    logic signed [PROD_W-1:0]  prod_b_next;
    logic signed [PROD_W-1:0]  prod_a_reg;
    logic signed [PROD_W-1:0]  prod_b_reg;
    ifm_pkg::ifm_tag_t         tag_m_reg;

    always_comb
    begin
        alpha       = div_tag.sum_zero ? ALPHA_HALF : div_alpha;
        alpha_rest  = ALPHA_ONE - alpha;
        prod_b_next = $signed({1'b0, alpha}) * $signed(div_tag.margin_b);
        prod_a_next = $signed({1'b0, alpha_rest}) * $signed(div_tag.margin_a);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            tag_m_reg  <= div_tag;
        end
    end

    // Subtract stage.
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_reg;
    ifm_pkg::ifm_tag_t        tag_s_reg;

    assign diff_next = {prod_b_reg[PROD_W-1], prod_b_reg} - {prod_a_reg[PROD_W-1], prod_a_reg};

    always_ff @(posedge clk)
    begin
        if (en[ST_SUB])
        begin
            diff_reg  <= diff_next;
            tag_s_reg <= tag_m_reg;
        end
    end

    // Clamp stage: the arithmetic shift rounds toward minus infinity.
    logic signed [DIFF_W-1:0] diff_sh;
    logic signed [SH_W-1:0]   share_raw;
    logic signed [SH_W-1:0]   cap_sh;
    logic signed [MW-1:0]     share_flow;
    logic signed [MW-1:0]     flow_next;
    logic signed [MW-1:0]     flow_reg;
    logic signed [MW-1:0]     ma_c_reg;
    logic signed [MW-1:0]     mb_c_reg;

    always_comb
    begin
        diff_sh   = diff_reg >>> ALPHA_BITS;
        share_raw = diff_sh[SH_W-1:0];
        cap_sh    = SH_W'(link_capacity_reg);
        if (share_raw > cap_sh)
        begin
            share_flow = MW'(link_capacity_reg);
        end
        else if (share_raw < -cap_sh)
        begin
            share_flow = MW'(0) - MW'(link_capacity_reg);
        end
        else
        begin
            share_flow = share_raw[MW-1:0];
        end
        flow_next = tag_s_reg.use_share ? share_flow : tag_s_reg.veto_flow;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_CLP])
        begin
            flow_reg <= flow_next;
            ma_c_reg <= tag_s_reg.margin_a;
            mb_c_reg <= tag_s_reg.margin_b;
        end
    end

    // Output stage with saturation to the signed margin range.
    logic signed [MW:0]   na_wide;
    logic signed [MW:0]   nb_wide;
    logic signed [MW-1:0] na_next;
    logic signed [MW-1:0] nb_next;
    logic signed [MW-1:0] na_reg;
    logic signed [MW-1:0] nb_reg;
    logic signed [MW-1:0] flow_out_reg;

    always_comb
    begin
        na_wide = {ma_c_reg[MW-1], ma_c_reg} + {flow_reg[MW-1], flow_reg};
        nb_wide = {mb_c_reg[MW-1], mb_c_reg} - {flow_reg[MW-1], flow_reg};
        if (na_wide[MW] != na_wide[MW-1])
        begin
            na_next = na_wide[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
        end
        else
        begin
            na_next = na_wide[MW-1:0];
        end
        if (nb_wide[MW] != nb_wide[MW-1])
        begin
            nb_next = nb_wide[MW] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}};
        end
        else
        begin
            nb_next = nb_wide[MW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            flow_out_reg <= flow_reg;
        end
    end

    assign m_tdata = {flow_out_reg, nb_reg, na_reg};

endmodule

// File: hdl/ifm_alpha_div.sv
// ----------------------------------------------------------------------------
// Alpha divider
// Pipelined restoring divider, one quotient bit per stage, that forms
// floor(dividend * 2^ALPHA_BITS / divisor) for dividend <= divisor.
// ----------------------------------------------------------------------------
module ifm_alpha_div #(
    parameter int ALPHA_BITS = ifm_pkg::ALPHA_BITS_DEF
) (
    input  logic                           clk,
    input  logic [ALPHA_BITS:0]            en,
    input  logic [ifm_pkg::DEMAND_W-1:0]   dividend,
    input  logic [ifm_pkg::SUM_W-1:0]      divisor,
    input  ifm_pkg::ifm_tag_t              tag_in,
    output logic [ALPHA_BITS:0]            alpha,
    output ifm_pkg::ifm_tag_t              tag_out
);

    localparam int NSTG  = ALPHA_BITS + 1;
    localparam int REM_W = ifm_pkg::SUM_W + 1;

    logic [REM_W-1:0]           rem_reg   [NSTG];
    logic [REM_W-1:0]           rem_next  [NSTG];
    logic [ifm_pkg::SUM_W-1:0]  dvs_reg   [NSTG];
    logic [ifm_pkg::SUM_W-1:0]  dvs_next  [NSTG];
    logic [NSTG-1:0]            q_reg     [NSTG];
    logic [NSTG-1:0]            q_next    [NSTG];
    ifm_pkg::ifm_tag_t          tag_reg   [NSTG];
    ifm_pkg::ifm_tag_t          tag_next  [NSTG];

    // The partial remainder stays below the divisor, so shifting it left
    // by one always fits in REM_W bits.
    always_comb
    begin
        logic [REM_W-1:0]          rem_in;
        logic [REM_W-1:0]          rem_sub;
        logic [ifm_pkg::SUM_W-1:0] dvs_in;
        logic [NSTG-1:0]           q_in;
        logic                      ge;
        for (int k = 0; k < NSTG; k++)
        begin
            if (k == 0)
            begin
                rem_in      = REM_W'(dividend);
                dvs_in      = divisor;
                q_in        = '0;
                tag_next[k] = tag_in;
            end
            else
            begin
                rem_in      = {rem_reg[k-1][REM_W-2:0], 1'b0};
                dvs_in      = dvs_reg[k-1];
                q_in        = q_reg[k-1];
                tag_next[k] = tag_reg[k-1];
            end
            rem_sub     = rem_in - {1'b0, dvs_in};
            ge          = rem_in >= {1'b0, dvs_in};
            rem_next[k] = ge ? rem_sub : rem_in;
            dvs_next[k] = dvs_in;
            q_next[k]   = {q_in[NSTG-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next[k];
                dvs_reg[k] <= dvs_next[k];
                q_reg[k]   <= q_next[k];
                tag_reg[k] <= tag_next[k];
            end
        end
    end

    assign alpha   = q_reg[NSTG-1];
    assign tag_out = tag_reg[NSTG-1];

endmodule
